/* hw/rtl/afft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afft_pkg
// shared types and constants of the animation frame block
// ----------------------------------------------------------------------------
package afft_pkg;

   localparam int TIME_W  = 32;
   localparam int PERIOD_W = 24;
   localparam int FRAME_W = 16;
   localparam int OUT_W   = 17;

   typedef enum logic [2:0] {
      CSR_START_TIME   = 3'd0,
      CSR_FRAME_PERIOD = 3'd1,
      CSR_FIRST_FRAME  = 3'd2,
      CSR_LAST_FRAME   = 3'd3,
      CSR_LOOP_FRAMES  = 3'd4,
      CSR_FORCE_LOOP   = 3'd5
   } csr_index_type;

   // per item control that travels with the divider chain
   typedef struct packed {
      logic                 valid;
      logic                 early;    // not yet started
      logic                 single;   // single frame animation
      logic [FRAME_W-1:0]   first;
      logic [FRAME_W-1:0]   span;
      logic [FRAME_W-1:0]   loop;
   } ctl_type;

endpackage

/* hw/rtl/afft_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afft_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface afft_if #(parameter int W = 32);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/afft_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afft_div_cell
// one restoring division step: shift in one dividend bit, compare, subtract
// ----------------------------------------------------------------------------
module afft_div_cell #(
   parameter int QW = 8,
   parameter int RW = 25,
   parameter int DW = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  afft_pkg::ctl_type     ctl_i,
   input  logic [QW-1:0]         num_i,
   input  logic [RW-1:0]         rem_i,
   input  logic [DW-1:0]         div_i,
   output afft_pkg::ctl_type     ctl_o,
   output logic [QW-1:0]         num_o,
   output logic [RW-1:0]         rem_o,
   output logic [DW-1:0]         div_o
);
   logic [RW:0]   trial;
   logic [RW:0]   diff;
   logic          take;
   afft_pkg::ctl_type ctl_ff;
   logic [QW-1:0] num_ff, num_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff;

   always_comb begin
      trial  = {rem_i, num_i[QW-1]};
      diff   = trial - {{(RW+1-DW){1'b0}}, div_i};
      take   = (trial >= {{(RW+1-DW){1'b0}}, div_i});
      rem_in = take ? diff[RW-1:0] : trial[RW-1:0];
      num_in = {num_i[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_i.valid;
      end
      if (en) begin
         ctl_ff.early  <= ctl_i.early;
         ctl_ff.single <= ctl_i.single;
         ctl_ff.first  <= ctl_i.first;
         ctl_ff.span   <= ctl_i.span;
         ctl_ff.loop   <= ctl_i.loop;
         num_ff <= num_in;
         rem_ff <= rem_in;
         div_ff <= div_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign num_o = num_ff;
   assign rem_o = rem_ff;
   assign div_o = div_ff;
endmodule

/* hw/rtl/afft_wrap_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afft_wrap_cell
// one restoring step of the loop wrap modulo, 16 bit divisor
// ----------------------------------------------------------------------------
module afft_wrap_cell #(
   parameter int QW = 41
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [QW-1:0]         num_i,
   input  logic [16:0]           rem_i,
   input  logic [15:0]           div_i,
   output logic [QW-1:0]         num_o,
   output logic [16:0]           rem_o
);
   logic [17:0]   trial;
   logic          take;
   logic [QW-1:0] num_ff;
   logic [16:0]   rem_ff, rem_in;

   always_comb begin
      trial  = {rem_i, num_i[QW-1]};
      take   = (trial >= {2'b00, div_i});
      rem_in = take ? 17'(trial - {2'b00, div_i}) : trial[16:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= {num_i[QW-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign num_o = num_ff;
   assign rem_o = rem_ff;
endmodule

/* hw/rtl/animation_frame_for_time.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_frame_for_time
// maps a time stamp to an animation frame and interpolation fraction
//
//  channel | dir | payload
//  req     | in  | current_time[31:0]
//  rsp     | out | frame_index[16:0] signed, fraction[16:0]
//  csr     | in  | csr_we, csr_index[2:0], csr_wdata[31:0]
//
// one item per cycle while the output is not stalled; the pipe runs through the
// quotient chain, fraction chain, wrap prep stage, wrap chain and output register.
// the whole pipe advances when the output register is free or being taken.
// reset clears valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module animation_frame_for_time #(
   parameter int FRAC_BITS        = 16,
   parameter int PERIOD_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   afft_if.sink        req,
   afft_if.source      rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int TW = afft_pkg::TIME_W + PERIOD_FRAC_BITS;  // t and count width
   localparam int DW = afft_pkg::PERIOD_W;
   localparam int RW = DW + 1;
   localparam int NQ = TW;
   localparam int NF = FRAC_BITS;
   localparam int FW = afft_pkg::FRAME_W;

   logic [31:0] start_ff;
   logic [23:0] period_ff;
   logic [15:0] first_ff, last_ff, loopr_ff;
   logic        force_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= 32'd0;
         period_ff <= 24'd25600;
         first_ff  <= 16'd0;
         last_ff   <= 16'd0;
         loopr_ff  <= 16'd0;
         force_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            afft_pkg::CSR_START_TIME:   start_ff  <= csr_wdata;
            afft_pkg::CSR_FRAME_PERIOD: period_ff <= csr_wdata[23:0];
            afft_pkg::CSR_FIRST_FRAME:  first_ff  <= csr_wdata[15:0];
            afft_pkg::CSR_LAST_FRAME:   last_ff   <= csr_wdata[15:0];
            afft_pkg::CSR_LOOP_FRAMES:  loopr_ff  <= csr_wdata[15:0];
            afft_pkg::CSR_FORCE_LOOP:   force_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipe advance
   logic out_valid_ff;
   logic en;
   assign en = !out_valid_ff || rsp.ready;
   assign req.ready = en;

   // entry stage
   afft_pkg::ctl_type ctl0;
   logic [TW-1:0] t0;
   logic [DW-1:0] d0;
   logic [15:0]   last_eff, span_c, loop_c;
   always_comb begin
      last_eff   = (last_ff < first_ff) ? first_ff : last_ff;
      span_c     = last_eff - first_ff;
      loop_c     = (force_ff && loopr_ff == 16'd0) ? span_c : loopr_ff;
      if (loop_c > span_c) loop_c = span_c;
      ctl0.valid  = req.valid;
      ctl0.early  = (req.data <= start_ff);
      ctl0.single = (first_ff == last_eff);
      ctl0.first  = first_ff;
      ctl0.span   = span_c;
      ctl0.loop   = loop_c;
      t0 = {req.data - start_ff, {PERIOD_FRAC_BITS{1'b0}}};
      d0 = (period_ff == '0) ? DW'(1) : period_ff;
   end

   // quotient chain: t / period
   afft_pkg::ctl_type qc [NQ+1];
   logic [TW-1:0] qn [NQ+1];
   logic [RW-1:0] qr [NQ+1];
   logic [DW-1:0] qd [NQ+1];
   assign qc[0] = ctl0;
   assign qn[0] = t0;
   assign qr[0] = '0;
   assign qd[0] = d0;
   for (genvar i = 0; i < NQ; i++) begin : g_q
      afft_div_cell #(.QW(TW), .RW(RW), .DW(DW)) u_cell (
         .clock, .reset, .en,
         .ctl_i(qc[i]), .num_i(qn[i]), .rem_i(qr[i]), .div_i(qd[i]),
         .ctl_o(qc[i+1]), .num_o(qn[i+1]), .rem_o(qr[i+1]), .div_o(qd[i+1]));
   end

   // fraction chain: (rem << FRAC_BITS) / period, count rides along in num
   localparam int FQ = TW + NF;
   afft_pkg::ctl_type fc [NF+1];
   logic [FQ-1:0] fn [NF+1];
   logic [RW-1:0] fr [NF+1];
   logic [DW-1:0] fd [NF+1];
   assign fc[0] = qc[NQ];
   assign fn[0] = {{NF{1'b0}}, qn[NQ]};
   assign fr[0] = qr[NQ];
   assign fd[0] = qd[NQ];
   for (genvar i = 0; i < NF; i++) begin : g_f
      afft_div_cell #(.QW(FQ), .RW(RW), .DW(DW)) u_cell (
         .clock, .reset, .en,
         .ctl_i(fc[i]), .num_i(fn[i]), .rem_i(fr[i]), .div_i(fd[i]),
         .ctl_o(fc[i+1]), .num_o(fn[i+1]), .rem_o(fr[i+1]), .div_o(fd[i+1]));
   end

   logic [TW-1:0] count_f;
   logic [NF-1:0] frac_f;
   assign count_f = fn[NF][FQ-1:NF];
   assign frac_f  = fn[NF][NF-1:0];

   // wrap prep stage: decide path, form x = count - span (when past end)
   afft_pkg::ctl_type wc_ff;
   logic [TW-1:0] cnt_ff, x_ff;
   logic [NF-1:0] fr_ff;
   logic          past_ff;
   logic [TW:0]   sum_w;
   always_comb sum_w = {{(TW+1-FW){1'b0}}, fc[NF].first} + {1'b0, count_f};
   always_ff @(posedge clock) begin
      if (reset) wc_ff.valid <= 1'b0;
      else if (en) wc_ff.valid <= fc[NF].valid;
      if (en) begin
         wc_ff.early  <= fc[NF].early;
         wc_ff.single <= fc[NF].single;
         wc_ff.first  <= fc[NF].first;
         wc_ff.span   <= fc[NF].span;
         wc_ff.loop   <= fc[NF].loop;
         cnt_ff  <= count_f;
         fr_ff   <= frac_f;
         past_ff <= sum_w > {{(TW+1-FW){1'b0}}, fc[NF].first + fc[NF].span};
         x_ff    <= count_f - {{(TW-FW){1'b0}}, fc[NF].span};
      end
   end

   // wrap chain: frame = first + span - loop + ((count - span) mod loop)
   afft_pkg::ctl_type pc [NQ+1];
   logic [TW-1:0] pn [NQ+1];
   logic [16:0]   pr [NQ+1];
   logic [TW-1:0] pcnt [NQ+1];
   logic [NF-1:0] pfr [NQ+1];
   logic          ppast [NQ+1];
   assign pc[0] = wc_ff;
   assign pn[0] = x_ff;
   assign pr[0] = '0;
   assign pcnt[0] = cnt_ff;
   assign pfr[0]  = fr_ff;
   assign ppast[0] = past_ff;
   for (genvar i = 0; i < NQ; i++) begin : g_w
      afft_pkg::ctl_type c_ff;
      logic [TW-1:0] k_ff;
      logic [NF-1:0] f_ff;
      logic          p_ff;
      afft_wrap_cell #(.QW(TW)) u_cell (
         .clock, .en, .num_i(pn[i]), .rem_i(pr[i]),
         .div_i((pc[i].loop == '0) ? 16'd1 : pc[i].loop),
         .num_o(pn[i+1]), .rem_o(pr[i+1]));
      always_ff @(posedge clock) begin
         if (reset) c_ff.valid <= 1'b0;
         else if (en) c_ff.valid <= pc[i].valid;
         if (en) begin
            c_ff.early  <= pc[i].early;
            c_ff.single <= pc[i].single;
            c_ff.first  <= pc[i].first;
            c_ff.span   <= pc[i].span;
            c_ff.loop   <= pc[i].loop;
            k_ff <= pcnt[i];
            f_ff <= pfr[i];
            p_ff <= ppast[i];
         end
      end
      assign pc[i+1] = c_ff;
      assign pcnt[i+1] = k_ff;
      assign pfr[i+1]  = f_ff;
      assign ppast[i+1] = p_ff;
   end

   // output stage
   afft_pkg::ctl_type lc;
   logic [16:0] frame_c, frac_c;
   logic [NF:0] one_c;
   assign lc = pc[NQ];
   always_comb begin
      one_c = {1'b1, {NF{1'b0}}};
      frac_c = 17'({1'b0, pfr[NQ]});
      frame_c = 17'({1'b0, lc.first} + pcnt[NQ][16:0]);
      priority if (lc.early) begin
         frame_c = {1'b0, lc.first};
         frac_c  = '0;
      end else if (lc.single) begin
         frame_c = {1'b0, lc.first};
         frac_c  = 17'(one_c);
      end else if (ppast[NQ]) begin
         if (lc.loop == '0) begin
            frame_c = '1;
         end else begin
            frame_c = 17'({1'b0, lc.first} + {1'b0, lc.span} - {1'b0, lc.loop}
                          + pr[NQ]);
            if (lc.loop == 16'd1) frac_c = 17'(one_c);
         end
      end else begin
      end
   end

   logic [16:0] frame_ff, frac_ff;
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (en) out_valid_ff <= lc.valid;
      if (en) begin
         frame_ff <= frame_c;
         frac_ff  <= frac_c;
      end
   end
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = {frame_ff, frac_ff};

   logic unused;
   assign unused = ^{pn[NQ], fr[NF], fd[NF]};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result moved while stalled");
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("accept while output held");
   a_early_frac: assert property (@(posedge clock) disable iff (reset)
      en && lc.valid && lc.early |=> frac_ff == '0)
      else $error("early item with nonzero fraction");
endmodule
